// ===== rtl/core/ftrm_pkg.sv =====
// Shared types and constants of the fan tachometer rpm monitor.
package ftrm_pkg;

  localparam int TIME_W = 32;
  localparam int RPM_W  = 25;
  localparam int PPR_W  = 4;
  localparam int FAN_IN_W = 2;

  localparam logic [RPM_W-1:0] RPM_MAX = 25'd30000000;
  localparam logic [PPR_W-1:0] PPR_MIN = 4'd1;
  localparam logic [PPR_W-1:0] PPR_MAX = 4'd8;

  localparam logic [PPR_W-1:0]  PPR_RESET     = 4'd2;
  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd500000;

  // Results are reported for at most this many fans on a poll.
  localparam int MAX_OUT = 4;

  // Serial divider: 60e6 fits in 26 bits, period times pulses in 36 bits.
  localparam int DIV_NUM_W = 26;
  localparam int DIV_DEN_W = TIME_W + PPR_W;
  localparam int DIV_CNT_W = 5;
  localparam logic [DIV_NUM_W-1:0] RPM_NUMERATOR = 26'd60000000;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_PPR     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 8'd1;

  // Item kinds carried on the input tuser.
  localparam logic ACT_EDGE = 1'b0;
  localparam logic ACT_POLL = 1'b1;

endpackage

// ===== rtl/core/ftrm_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
module ftrm_div
  import ftrm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quot
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [DIV_NUM_W-1:0] quo_r, quo_nxt;
  logic [DIV_DEN_W:0]   trial;
  logic                 take;

  // The low end of quo_r shifts in quotient bits while the numerator
  // shifts out at the top.
  assign trial = {rem_r, quo_r[DIV_NUM_W-1]};
  assign take  = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_NUM_W - 1);
      rem_nxt  = '0;
      den_nxt  = den;
      quo_nxt  = num;
    end else if (busy_r) begin
      if (take) begin
        rem_nxt = DIV_DEN_W'(trial - {1'b0, den_r});
      end else begin
        rem_nxt = trial[DIV_DEN_W-1:0];
      end
      quo_nxt = {quo_r[DIV_NUM_W-2:0], take};
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

// ===== rtl/core/fan_tach_rpm_monitor_top.sv =====
// Top level of the fan tachometer rpm monitor: control, state memories, output register.
//
// An edge word passes through the record read, the divider load, the serial divider
// that forms 60000000 / (period * pulses_per_rev), one registered reciprocal multiply
// for the window average and the result load. A poll word steps through the fans with
// one read and one check-and-write of the per-fan record memory for each. Either kind
// waits while the output register is held by the result side. Per-fan records live
// in a FANS-entry memory with a valid bit per entry, and the readings live in a
// FANS*WINDOW memory where a per-fan wrap flag marks which entries hold data, so no
// clearing pass is needed after reset. Results wait in an output register, and the
// input is ready again once the sequencer is back in idle after the last record
// write-back of a word. Fan indexes at or above FANS are dropped silently.
module fan_tach_rpm_monitor_top
  import ftrm_pkg::*;
#(
  parameter int FANS   = 4,
  parameter int WINDOW = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: fan [1:0], time_us [33:2], zero fill [39:34]
  input  logic [39:0]           in_tdata,
  // in_tuser: action [0]
  input  logic                  in_tuser,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // out_tdata: fan_id [1:0], rpm_now [26:2], reading [51:27], accepted [52],
  // stalled [53], zero fill [55:54]
  output logic [55:0]           out_tdata,
  output logic                  out_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int FA_W   = (FANS > 1) ? $clog2(FANS) : 1;
  localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int WDEPTH = FANS * WINDOW;
  localparam int WA_W   = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int SUM_W  = RPM_W + $clog2(WINDOW + 1);
  // avg = (sum * RECIP) >> SHIFT is exact for every sum below 2^SUM_W.
  localparam int SHIFT  = SUM_W + $clog2(WINDOW);
  localparam int M_W    = SUM_W + 1;
  localparam logic [63:0] RECIP64 =
    ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [M_W-1:0] RECIP = RECIP64[M_W-1:0];
  localparam int PROD_W = SUM_W + M_W;
  localparam int N_OUT  = (FANS < MAX_OUT) ? FANS : MAX_OUT;

  typedef struct packed {
    logic              seen;
    logic              wrapped;
    logic [RPM_W-1:0]  rpt;
    logic [SUM_W-1:0]  sum;
    logic [POS_W-1:0]  pos;
    logic [TIME_W-1:0] last_t;
  } fan_rec_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_E_RD, ST_E_DIV, ST_E_AVG, ST_E_OUT, ST_P_RD, ST_P_CHK
  } state_t;

  // Input word fields.
  logic                in_action;
  logic [FAN_IN_W-1:0] in_fan;
  logic [TIME_W-1:0]   in_time;
  logic                in_hs;

  assign in_action = in_tuser;
  assign in_fan    = in_tdata[1:0];
  assign in_time   = in_tdata[33:2];
  assign in_hs     = in_tvalid & in_tready;

  // Configuration registers.
  logic [PPR_W-1:0]  ppr_r;
  logic [TIME_W-1:0] timeout_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppr_r     <= PPR_RESET;
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_PPR) begin
        ppr_r <= cfg_data[PPR_W-1:0];
      end else if (cfg_index == CFG_TIMEOUT) begin
        timeout_r <= cfg_data[TIME_W-1:0];
      end
    end
  end

  // Control registers.
  state_t            state_r;
  logic [FA_W-1:0]   cur_fan_r;
  logic [TIME_W-1:0] time_r;
  logic [RPM_W-1:0]  rpm_r;
  logic [SUM_W-1:0]  sum_r;
  logic [PROD_W-1:0] prod_r;

  // Output register.
  logic              out_valid_r;
  logic [1:0]        o_fan_r;
  logic [RPM_W-1:0]  o_now_r;
  logic [RPM_W-1:0]  o_reading_r;
  logic              o_acc_r;
  logic              o_stall_r;
  logic              o_last_r;
  logic              out_free;

  assign out_free = ~out_valid_r | out_tready;

  // Per-fan record memory with valid bits; entries not yet written read as zero.
  fan_rec_t          fan_mem [FANS];
  logic [FANS-1:0]   fan_vld_r;
  fan_rec_t          fan_q_r;
  logic              fan_qv_r;
  logic [FA_W-1:0]   fan_ra;
  fan_rec_t          rec;
  logic              fan_we;
  fan_rec_t          fan_wd;

  // Reading window memory.
  logic [RPM_W-1:0]  win_mem [WDEPTH];
  logic [RPM_W-1:0]  win_q_r;
  logic [WA_W-1:0]   win_a;
  logic              win_re;
  logic              win_we;

  // Divider.
  logic                 div_start;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quot;
  logic [DIV_DEN_W-1:0] div_den;

  always_comb begin
    if (state_r == ST_IDLE) begin
      fan_ra = (in_action == ACT_POLL) ? '0 : FA_W'(in_fan);
    end else begin
      fan_ra = cur_fan_r;
    end
  end

  assign rec = fan_qv_r ? fan_q_r : '0;

  // Period, pulses clamp and divisor.
  logic [TIME_W-1:0] period;
  logic [PPR_W-1:0]  ppr_c;

  always_comb begin
    period = time_r - rec.last_t;
    if (period == '0) begin
      period = TIME_W'(1);
    end
    if (ppr_r < PPR_MIN) begin
      ppr_c = PPR_MIN;
    end else if (ppr_r > PPR_MAX) begin
      ppr_c = PPR_MAX;
    end else begin
      ppr_c = ppr_r;
    end
  end

  assign div_den   = DIV_DEN_W'(period) * DIV_DEN_W'(ppr_c);
  assign div_start = (state_r == ST_E_RD);

  ftrm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (RPM_NUMERATOR),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Window address of the current fan's write position.
  assign win_a  = WA_W'(cur_fan_r) * WA_W'(WINDOW) + WA_W'(rec.pos);
  assign win_re = (state_r == ST_E_RD);
  assign win_we = (state_r == ST_E_DIV) && div_done;

  // New reading, saturated, and the updated window sum.
  logic [RPM_W-1:0] rpm_c;
  logic [RPM_W-1:0] old_c;
  logic [SUM_W-1:0] sum_c;

  always_comb begin
    if (div_quot > DIV_NUM_W'(RPM_MAX)) begin
      rpm_c = RPM_MAX;
    end else begin
      rpm_c = div_quot[RPM_W-1:0];
    end
    old_c = rec.wrapped ? win_q_r : '0;
    sum_c = rec.sum - SUM_W'(old_c) + SUM_W'(rpm_c);
  end

  // Outlier limit from the window average.
  logic [RPM_W-1:0] avg_c;
  logic [RPM_W:0]   lim_c;
  logic             acc_c;
  logic [POS_W-1:0] pos_nxt;
  logic             pos_end;

  assign avg_c   = prod_r[SHIFT +: RPM_W];
  assign lim_c   = {1'b0, avg_c} + {2'b00, avg_c[RPM_W-1:1]};
  assign acc_c   = ({1'b0, rpm_r} <= lim_c);
  assign pos_end = (rec.pos == POS_W'(WINDOW - 1));
  assign pos_nxt = pos_end ? '0 : rec.pos + POS_W'(1);

  // Poll check of one fan.
  logic             stall_c;
  logic             poll_emit;
  logic             poll_last;
  logic             poll_end;

  assign stall_c   = ~rec.seen && ((time_r - rec.last_t) > timeout_r);
  assign poll_emit = (32'(cur_fan_r) < N_OUT);
  assign poll_last = (32'(cur_fan_r) == N_OUT - 1);
  assign poll_end  = (32'(cur_fan_r) == FANS - 1);

  // A result word enters the output register this cycle.
  logic             out_load;

  assign out_load = ((state_r == ST_E_OUT) && out_free) ||
                    ((state_r == ST_P_CHK) && out_free && poll_emit);

  // Record write-back.
  always_comb begin
    fan_we = 1'b0;
    fan_wd = rec;
    if (state_r == ST_E_OUT && out_free) begin
      fan_we         = 1'b1;
      fan_wd.last_t  = time_r;
      fan_wd.pos     = pos_nxt;
      fan_wd.wrapped = rec.wrapped | pos_end;
      fan_wd.sum     = sum_r;
      fan_wd.seen    = 1'b1;
      if (acc_c) begin
        fan_wd.rpt = rpm_r;
      end
    end else if (state_r == ST_P_CHK && (out_free || !poll_emit)) begin
      fan_we      = 1'b1;
      fan_wd.seen = 1'b0;
      if (stall_c) begin
        fan_wd.rpt = '0;
      end
    end
  end

  // Memories.
  always_ff @(posedge clk) begin
    fan_q_r <= fan_mem[fan_ra];
    if (fan_we) begin
      fan_mem[cur_fan_r] <= fan_wd;
    end
    if (win_re) begin
      win_q_r <= win_mem[win_a];
    end
    if (win_we) begin
      win_mem[win_a] <= rpm_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fan_vld_r <= '0;
      fan_qv_r  <= 1'b0;
    end else begin
      fan_qv_r <= fan_vld_r[fan_ra];
      if (fan_we) begin
        fan_vld_r[cur_fan_r] <= 1'b1;
      end
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cur_fan_r   <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_hs) begin
            time_r <= in_time;
            if (in_action == ACT_POLL) begin
              cur_fan_r <= '0;
              state_r   <= ST_P_CHK;
            end else if (32'(in_fan) < FANS) begin
              cur_fan_r <= FA_W'(in_fan);
              state_r   <= ST_E_RD;
            end
          end
        end
        ST_E_RD: begin
          state_r <= ST_E_DIV;
        end
        ST_E_DIV: begin
          if (div_done) begin
            rpm_r   <= rpm_c;
            sum_r   <= sum_c;
            state_r <= ST_E_AVG;
          end
        end
        ST_E_AVG: begin
          prod_r  <= PROD_W'(sum_r) * PROD_W'(RECIP);
          state_r <= ST_E_OUT;
        end
        ST_E_OUT: begin
          if (out_free) begin
            o_fan_r     <= 2'(cur_fan_r);
            o_now_r     <= acc_c ? rpm_r : rec.rpt;
            o_reading_r <= rpm_r;
            o_acc_r     <= acc_c;
            o_stall_r   <= 1'b0;
            o_last_r    <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        ST_P_RD: begin
          state_r <= ST_P_CHK;
        end
        ST_P_CHK: begin
          if (out_free || !poll_emit) begin
            if (poll_emit) begin
              o_fan_r     <= 2'(cur_fan_r);
              o_now_r     <= stall_c ? '0 : rec.rpt;
              o_reading_r <= '0;
              o_acc_r     <= 1'b0;
              o_stall_r   <= stall_c;
              o_last_r    <= poll_last;
            end
            if (poll_end) begin
              state_r <= ST_IDLE;
            end else begin
              cur_fan_r <= cur_fan_r + FA_W'(1);
              state_r   <= ST_P_RD;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {2'b00, o_stall_r, o_acc_r, o_reading_r, o_now_r, o_fan_r};

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the fan tachometer rpm monitor: directed and random edge and poll words.
module testbench;
  import ftrm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FAN_COUNT  = 4;
  localparam int WINDOW_LEN = 10;
  localparam logic [63:0] MINUTE_US = 64'd60000000;
  localparam logic [63:0] RPM_CEIL  = 64'd30000000;
  localparam logic [3:0]  PPR_FLOOR = 4'd1;
  localparam logic [3:0]  PPR_CEIL  = 4'd8;
  // Indexes past the register list; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_TIMEOUT + 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

  typedef struct packed {
    logic        action;
    logic [1:0]  fan;
    logic [31:0] time_us;
  } tach_word_t;

  typedef struct packed {
    logic [1:0]  fan_id;
    logic [24:0] rpm_now;
    logic [24:0] reading;
    logic        accepted;
    logic        stalled;
    logic        last;
  } fan_status_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [39:0]           in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [55:0]           out_tdata;
  logic                  out_tlast;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  fan_tach_rpm_monitor_top #(
    .FANS   (FAN_COUNT),
    .WINDOW (WINDOW_LEN)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  tach_word_t  pending_words[$];
  fan_status_t expected_status[$];
  int          mismatches = 0;
  int          send_idle_pct = 23;
  int          recv_idle_pct = 86;

  // Predicted state of the block.
  logic [3:0]  ppr_cfg = PPR_RESET;
  logic [31:0] timeout_cfg = TIMEOUT_RESET;
  logic [31:0] fan_last_us [FAN_COUNT];
  logic [24:0] rpm_hist [FAN_COUNT][WINDOW_LEN];
  int          hist_pos [FAN_COUNT];
  logic [31:0] hist_sum [FAN_COUNT];
  logic [24:0] rpm_shown [FAN_COUNT];
  logic        edge_flag [FAN_COUNT];

  // Stimulus generator's view of each fan.
  logic [31:0] gen_last [FAN_COUNT];
  logic [31:0] gen_period [FAN_COUNT];

  initial begin
    for (int f = 0; f < FAN_COUNT; f++) begin
      fan_last_us[f] = '0;
      hist_pos[f] = 0;
      hist_sum[f] = '0;
      rpm_shown[f] = '0;
      edge_flag[f] = 1'b0;
      gen_last[f] = '0;
      gen_period[f] = '0;
      for (int k = 0; k < WINDOW_LEN; k++) rpm_hist[f][k] = '0;
    end
  end

  function automatic void predict_rpm_status(tach_word_t w);
    logic [3:0]  ppr;
    logic [31:0] period;
    logic [31:0] avg;
    logic [31:0] limit;
    logic [63:0] quotient;
    logic [24:0] rpm;
    int          pos;
    fan_status_t s;
    if (w.action == ACT_EDGE) begin
      ppr = (ppr_cfg < PPR_FLOOR) ? PPR_FLOOR : (ppr_cfg > PPR_CEIL) ? PPR_CEIL : ppr_cfg;
      period = w.time_us - fan_last_us[w.fan];
      if (period == 0) period = 1;
      quotient = MINUTE_US / (64'(period) * 64'(ppr));
      rpm = (quotient > RPM_CEIL) ? RPM_CEIL[24:0] : quotient[24:0];
      pos = hist_pos[w.fan];
      hist_sum[w.fan] = hist_sum[w.fan] - 32'(rpm_hist[w.fan][pos]) + 32'(rpm);
      rpm_hist[w.fan][pos] = rpm;
      hist_pos[w.fan] = (pos + 1 >= WINDOW_LEN) ? 0 : pos + 1;
      avg = hist_sum[w.fan] / WINDOW_LEN;
      limit = avg + avg / 2;
      s.accepted = (32'(rpm) <= limit);
      if (s.accepted) rpm_shown[w.fan] = rpm;
      edge_flag[w.fan] = 1'b1;
      fan_last_us[w.fan] = w.time_us;
      s.fan_id = w.fan;
      s.rpm_now = rpm_shown[w.fan];
      s.reading = rpm;
      s.stalled = 1'b0;
      s.last = 1'b1;
      expected_status.push_back(s);
    end else begin
      for (int f = 0; f < FAN_COUNT; f++) begin
        s.stalled = !edge_flag[f] && ((w.time_us - fan_last_us[f]) > timeout_cfg);
        if (s.stalled) rpm_shown[f] = '0;
        edge_flag[f] = 1'b0;
        s.fan_id = f[1:0];
        s.rpm_now = rpm_shown[f];
        s.reading = '0;
        s.accepted = 1'b0;
        s.last = (f == FAN_COUNT - 1);
        expected_status.push_back(s);
      end
    end
  endfunction

  // Driver: a word is taken at an edge where valid and ready are both high.
  tach_word_t word_on_bus;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_rpm_status(word_on_bus);
      if (!in_tvalid || in_tready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          word_on_bus = pending_words.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {6'd0, word_on_bus.time_us, word_on_bus.fan};
          in_tuser <= word_on_bus.action;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result word with the oldest prediction.
  always @(posedge clk) begin : monitor
    fan_status_t got;
    fan_status_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.fan_id = out_tdata[1:0];
        got.rpm_now = out_tdata[26:2];
        got.reading = out_tdata[51:27];
        got.accepted = out_tdata[52];
        got.stalled = out_tdata[53];
        got.last = out_tlast;
        if (expected_status.size() == 0) begin
          $error("result word with nothing expected: fan_id %0d rpm_now %0d",
                 got.fan_id, got.rpm_now);
          mismatches++;
        end else begin
          want = expected_status.pop_front();
          if (got.fan_id !== want.fan_id) begin
            $error("fan_id: expected %0d, got %0d", want.fan_id, got.fan_id);
            mismatches++;
          end
          if (got.rpm_now !== want.rpm_now) begin
            $error("rpm_now: expected %0d, got %0d", want.rpm_now, got.rpm_now);
            mismatches++;
          end
          if (got.reading !== want.reading) begin
            $error("reading: expected %0d, got %0d", want.reading, got.reading);
            mismatches++;
          end
          if (got.accepted !== want.accepted) begin
            $error("accepted: expected %0b, got %0b", want.accepted, got.accepted);
            mismatches++;
          end
          if (got.stalled !== want.stalled) begin
            $error("stalled: expected %0b, got %0b", want.stalled, got.stalled);
            mismatches++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            mismatches++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic push_word(input logic action, input logic [1:0] fan, input logic [31:0] t);
    tach_word_t w;
    w.action = action;
    w.fan = fan;
    w.time_us = t;
    pending_words.push_back(w);
    if (action == ACT_EDGE) gen_last[fan] = t;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_PPR) ppr_cfg = value[3:0];
    else if (idx == CFG_TIMEOUT) timeout_cfg = value;
  endtask

  // Returns once every word is sent and every predicted result has arrived. The check
  // runs at the falling edge so that it sees the settled state of the rising edge.
  task automatic drain();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_tvalid || expected_status.size() != 0);
  endtask

  // Mostly steady fans with jitter, some glitches and speed steps, mixed with polls and noise.
  task automatic queue_random(input int count);
    int          r;
    logic [1:0]  f;
    logic [31:0] p;
    logic [31:0] t;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      f = 2'($urandom_range(FAN_COUNT - 1));
      if (r < 70) begin
        if (gen_period[f] == 0 || $urandom_range(19) == 0)
          gen_period[f] = $urandom_range(1500, 50000);
        p = gen_period[f];
        if ($urandom_range(9) == 0) p = $urandom_range(p / 4);
        else p = p - p / 8 + $urandom_range(p / 4);
        push_word(ACT_EDGE, f, gen_last[f] + p);
      end else if (r < 88) begin
        t = gen_last[f] + (($urandom_range(3) == 0) ? $urandom : $urandom_range(200000));
        push_word(ACT_POLL, 2'($urandom_range(FAN_COUNT - 1)), t);
      end else begin
        push_word(1'($urandom_range(1)), f, $urandom);
      end
    end
  endtask

  task automatic run_phase(input logic [3:0] ppr, input logic [31:0] timeout,
                           input int send_idle, input int recv_idle, input int count);
    write_reg(CFG_PPR, {28'd0, ppr});
    write_reg(CFG_TIMEOUT, timeout);
    send_idle_pct = send_idle;
    recv_idle_pct = recv_idle;
    queue_random(count);
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: zero period, full-range period, timestamp wrap, polls at the extremes.
    push_word(ACT_EDGE, 2'd0, 32'h0000_0000);
    push_word(ACT_EDGE, 2'd0, 32'hFFFF_FFFF);
    push_word(ACT_EDGE, 2'd1, 32'hFFFF_FFF0);
    push_word(ACT_EDGE, 2'd1, 32'h0000_0010);
    push_word(ACT_EDGE, 2'd2, 32'd30000);
    push_word(ACT_EDGE, 2'd3, 32'd15000);
    push_word(ACT_POLL, 2'd0, 32'h7FFF_FFFF);
    push_word(ACT_POLL, 2'd3, 32'hFFFF_FFFF);
    drain();

    // Pulses of zero act as one; a zero timeout stalls every fan with a nonzero edge age.
    write_reg(CFG_PPR, 32'd0);
    write_reg(CFG_TIMEOUT, 32'd0);
    write_reg(CFG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(CFG_SPARE_HI, 32'h0000_0005);
    push_word(ACT_EDGE, 2'd2, 32'h8000_0000);
    push_word(ACT_EDGE, 2'd2, 32'h8000_0000);
    push_word(ACT_POLL, 2'd1, 32'h8000_0000);
    push_word(ACT_POLL, 2'd2, 32'h8000_0000);
    drain();

    // Pulses above eight act as eight; the widest timeout never stalls.
    write_reg(CFG_PPR, 32'd15);
    write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
    push_word(ACT_EDGE, 2'd3, 32'd18750);
    push_word(ACT_EDGE, 2'd3, 32'd22500);
    push_word(ACT_EDGE, 2'd3, 32'd26250);
    push_word(ACT_POLL, 2'd0, 32'd0);
    push_word(ACT_POLL, 2'd0, 32'd0);
    drain();

    run_phase(4'd2, TIMEOUT_RESET, 23, 86, 38);
    run_phase(4'd1, 32'd1, 23, 86, 38);
    run_phase(4'd8, 32'hFFFF_FFFF, 86, 23, 38);
    run_phase(4'd0, 32'd0, 86, 23, 38);
    run_phase(4'd15, 32'd100000, 0, 0, 38);
    run_phase(4'd4, 32'd20000, 0, 0, 38);
    run_phase(4'd3, $urandom_range(1000, 300000), 0, 0, 38);

    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
